// ===== sv/acmac_pkg.sv =====
// Package with shared types, constants and AES helper functions for the CMAC engine.
`timescale 1ns / 1ps
package acmac_pkg;

   localparam logic [7:0] CMAC_RB  = 8'h87;
   localparam logic [7:0] CMAC_PAD = 8'h80;

   localparam logic [1:0] CSR_KEY_HIGH    = 2'd0;
   localparam logic [1:0] CSR_KEY_LOW     = 2'd1;
   localparam logic [1:0] CSR_ENGINE_MODE = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUBKEY,
      ST_FINAL,
      ST_RUN,
      ST_OUT_HIGH,
      ST_OUT_LOW
   } state_type;

   typedef struct packed {
      logic start;
      logic [127:0] block;
   } aes_cmd_type;

   typedef struct packed {
      logic done;
      logic [127:0] result;
   } aes_rsp_type;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] t [256];
      t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[a];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // Doubling in GF(2^128) with the CMAC reduction constant.
   function automatic logic [127:0] gf_double(input logic [127:0] v);
      return {v[126:0], 1'b0} ^ {120'd0, (v[127] ? CMAC_RB : 8'h00)};
   endfunction

   // Keeps n leading bytes of w (n 0..7) and appends the pad byte.
   function automatic logic [63:0] pad_word(input logic [63:0] w, input logic [2:0] n);
      logic [63:0] keep;
      logic [63:0] pad;
      keep = ~(64'hffff_ffff_ffff_ffff >> {n, 3'b000});
      pad = {CMAC_PAD, 56'd0} >> {n, 3'b000};
      return (w & keep) | pad;
   endfunction

endpackage

// ===== sv/aes_cmac_engine_top.sv =====
// Top level of the AES-128 CMAC and ECB engine.
`timescale 1ns / 1ps
// A word that fills a block (the second word, or any last word) starts AES in the shared round
// unit; in CMAC mode a last word first sets up the final block, and the very first tag after
// a key write adds one more pass for the subkey. An ECB block or a CMAC tag then gives two
// result words, and the first word of a block is only buffered. req_stall is high whenever the
// engine is not idle, also while the result words are offered.
module aes_cmac_engine_top
   import acmac_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_data_word,
   input  logic [3:0]  req_valid_bytes,
   input  logic        req_message_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_tag_word,
   output logic        rsp_tag_last
);

   state_type    state_ff, state_in;
   logic [63:0]  key_high_ff, key_low_ff;
   logic         mode_ff;
   logic [127:0] chain_ff, chain_in;
   logic [63:0]  buffer_ff, buffer_in;
   logic         half_ff, half_in;
   logic [127:0] subkey_ff, subkey_in;
   logic         subkey_valid_ff, subkey_valid_in;
   logic [127:0] block_ff, block_in;
   logic         complete_ff, complete_in;
   logic [127:0] result_ff, result_in;

   aes_cmd_type  aes_cmd;
   aes_rsp_type  aes_rsp;
   logic         accept;
   logic [3:0]   nbytes;
   logic [127:0] fin_block;
   logic         fin_complete;
   logic [127:0] sub_use;
   logic         fin_start;
   logic         fin_pend_ff;

   acmac_aes_core u_aes (
      .clock (clock),
      .reset (reset),
      .key   ({key_high_ff, key_low_ff}),
      .cmd   (aes_cmd),
      .rsp   (aes_rsp)
   );

   assign accept = req_valid && !req_stall;
   assign nbytes = (req_valid_bytes > 4'd8) ? 4'd8 : req_valid_bytes;

   // The final pass starts in the first cycle of ST_FINAL.
   assign fin_start = (state_ff == ST_FINAL) && !fin_pend_ff;

   always_comb begin
      if (half_ff) begin
         fin_complete = (nbytes == 4'd8);
         fin_block = {buffer_ff, fin_complete ? req_data_word :
                      pad_word(req_data_word, nbytes[2:0])};
      end else begin
         fin_complete = 1'b0;
         fin_block = (nbytes == 4'd8) ? {req_data_word, CMAC_PAD, 56'd0} :
                     {pad_word(req_data_word, nbytes[2:0]), 64'd0};
      end
      sub_use = complete_ff ? subkey_ff : gf_double(subkey_ff);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (mode_ff || !req_message_end) begin
                  if (half_ff || (mode_ff && req_message_end)) begin
                     state_in = ST_RUN;
                  end
               end else if (!subkey_valid_ff) begin
                  state_in = ST_SUBKEY;
               end else begin
                  state_in = ST_FINAL;
               end
            end
         end
         ST_SUBKEY: if (aes_rsp.done) state_in = ST_FINAL;
         ST_FINAL:  if (aes_rsp.done) state_in = ST_OUT_HIGH;
         ST_RUN: begin
            if (aes_rsp.done) state_in = mode_ff ? ST_OUT_HIGH : ST_IDLE;
         end
         ST_OUT_HIGH: if (!rsp_stall) state_in = ST_OUT_LOW;
         ST_OUT_LOW:  if (!rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      chain_in        = chain_ff;
      buffer_in       = buffer_ff;
      half_in         = half_ff;
      subkey_in       = subkey_ff;
      subkey_valid_in = subkey_valid_ff;
      block_in        = block_ff;
      complete_in     = complete_ff;
      result_in       = result_ff;
      aes_cmd.start   = 1'b0;
      aes_cmd.block   = 128'd0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (mode_ff) begin
                  if (!half_ff && !req_message_end) begin
                     buffer_in = req_data_word;
                     half_in = 1'b1;
                  end else begin
                     half_in = 1'b0;
                     aes_cmd.start = 1'b1;
                     aes_cmd.block = half_ff ? {buffer_ff, req_data_word} :
                                     {req_data_word, 64'd0};
                  end
               end else if (!req_message_end) begin
                  if (!half_ff) begin
                     buffer_in = req_data_word;
                     half_in = 1'b1;
                  end else begin
                     half_in = 1'b0;
                     aes_cmd.start = 1'b1;
                     aes_cmd.block = chain_ff ^ {buffer_ff, req_data_word};
                  end
               end else begin
                  half_in = 1'b0;
                  block_in = fin_block;
                  complete_in = fin_complete;
                  if (!subkey_valid_ff) begin
                     aes_cmd.start = 1'b1;
                  end
               end
            end
         end
         ST_SUBKEY: begin
            if (aes_rsp.done) begin
               subkey_in = gf_double(aes_rsp.result);
               subkey_valid_in = 1'b1;
            end
         end
         ST_RUN: begin
            if (aes_rsp.done) begin
               if (mode_ff) result_in = aes_rsp.result;
               else chain_in = aes_rsp.result;
            end
         end
         default: begin
         end
      endcase
      if (state_ff == ST_FINAL && aes_rsp.done) begin
         result_in = aes_rsp.result;
         chain_in = 128'd0;
      end
      if (fin_start) begin
         aes_cmd.start = 1'b1;
         aes_cmd.block = chain_ff ^ block_ff ^ sub_use;
      end
      if (csr_write && csr_index inside {CSR_KEY_HIGH, CSR_KEY_LOW, CSR_ENGINE_MODE}) begin
         chain_in = 128'd0;
         half_in = 1'b0;
         if (csr_index == CSR_KEY_HIGH || csr_index == CSR_KEY_LOW) subkey_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         chain_ff        <= 128'd0;
         half_ff         <= 1'b0;
         subkey_valid_ff <= 1'b0;
         key_high_ff     <= 64'd0;
         key_low_ff      <= 64'd0;
         mode_ff         <= 1'b0;
         fin_pend_ff     <= 1'b0;
      end else begin
         state_ff        <= state_in;
         chain_ff        <= chain_in;
         half_ff         <= half_in;
         subkey_valid_ff <= subkey_valid_in;
         fin_pend_ff     <= (state_ff == ST_FINAL) && (state_in == ST_FINAL);
         if (csr_write) begin
            case (csr_index)
               CSR_KEY_HIGH:    key_high_ff <= csr_data;
               CSR_KEY_LOW:     key_low_ff  <= csr_data;
               CSR_ENGINE_MODE: mode_ff     <= csr_data[0];
               default: begin
               end
            endcase
         end
      end
      buffer_ff   <= buffer_in;
      subkey_ff   <= subkey_in;
      block_ff    <= block_in;
      complete_ff <= complete_in;
      result_ff   <= result_in;
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = (state_ff == ST_OUT_HIGH) || (state_ff == ST_OUT_LOW);
   assign rsp_tag_word = (state_ff == ST_OUT_LOW) ? result_ff[63:0] : result_ff[127:64];
   assign rsp_tag_last = (state_ff == ST_OUT_LOW);

   a_out_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT_HIGH && !rsp_stall) |=> state_ff == ST_OUT_LOW)
      else $error("low half must follow high half");
   a_final_needs_key: assert property (@(posedge clock) disable iff (reset)
      (fin_start) |-> subkey_valid_ff) else $error("final pass without subkey");
   a_no_half_in_output: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !half_ff) else $error("partial block kept across a result");

endmodule

// ===== sv/acmac_aes_core.sv =====
// Iterative AES-128 encryption unit: one round and one key expansion step per cycle.
`timescale 1ns / 1ps
module acmac_aes_core
   import acmac_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic [127:0] key,
   input  aes_cmd_type  cmd,
   output aes_rsp_type  rsp
);

   logic [127:0] state_ff, state_in;
   logic [127:0] rkey_ff, rkey_in;
   logic [3:0]   round_ff, round_in;
   logic         busy_ff, busy_in;
   logic [7:0]   rcon_ff, rcon_in;
   logic         done_ff, done_in;

   logic [7:0]   sb [16];
   logic [7:0]   sr [16];
   logic [7:0]   mc [16];
   logic [127:0] next_key;
   logic [127:0] round_out;
   logic [31:0]  kw;

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         sb[i] = sbox(state_ff[127 - 8 * i -: 8]);
      end
      for (int c = 0; c < 4; c++) begin
         for (int w = 0; w < 4; w++) begin
            sr[c * 4 + w] = sb[((c + w) % 4) * 4 + w];
         end
      end
      for (int c = 0; c < 4; c++) begin
         mc[c * 4]     = sr[c * 4] ^ sr[c * 4] ^ sr[c * 4 + 1] ^ sr[c * 4 + 2] ^ sr[c * 4 + 3]
                         ^ xtime(sr[c * 4] ^ sr[c * 4 + 1]);
         mc[c * 4 + 1] = sr[c * 4 + 1] ^ sr[c * 4] ^ sr[c * 4 + 1] ^ sr[c * 4 + 2]
                         ^ sr[c * 4 + 3] ^ xtime(sr[c * 4 + 1] ^ sr[c * 4 + 2]);
         mc[c * 4 + 2] = sr[c * 4 + 2] ^ sr[c * 4] ^ sr[c * 4 + 1] ^ sr[c * 4 + 2]
                         ^ sr[c * 4 + 3] ^ xtime(sr[c * 4 + 2] ^ sr[c * 4 + 3]);
         mc[c * 4 + 3] = sr[c * 4 + 3] ^ sr[c * 4] ^ sr[c * 4 + 1] ^ sr[c * 4 + 2]
                         ^ sr[c * 4 + 3] ^ xtime(sr[c * 4 + 3] ^ sr[c * 4]);
      end
      kw = {sbox(rkey_ff[23:16]) ^ rcon_ff, sbox(rkey_ff[15:8]), sbox(rkey_ff[7:0]),
            sbox(rkey_ff[31:24])};
      next_key[127:96] = rkey_ff[127:96] ^ kw;
      next_key[95:64]  = rkey_ff[95:64] ^ next_key[127:96];
      next_key[63:32]  = rkey_ff[63:32] ^ next_key[95:64];
      next_key[31:0]   = rkey_ff[31:0] ^ next_key[63:32];
      for (int i = 0; i < 16; i++) begin
         round_out[127 - 8 * i -: 8] = ((round_ff == 4'd10) ? sr[i] : mc[i])
                                       ^ next_key[127 - 8 * i -: 8];
      end
   end

   always_comb begin
      state_in = state_ff;
      rkey_in  = rkey_ff;
      round_in = round_ff;
      busy_in  = busy_ff;
      rcon_in  = rcon_ff;
      done_in  = 1'b0;
      if (cmd.start) begin
         state_in = cmd.block ^ key;
         rkey_in  = key;
         round_in = 4'd1;
         rcon_in  = 8'h01;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         state_in = round_out;
         rkey_in  = next_key;
         rcon_in  = xtime(rcon_ff);
         round_in = round_ff + 4'd1;
         if (round_ff == 4'd10) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         round_ff <= 4'd0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         round_ff <= round_in;
      end
      state_ff <= state_in;
      rkey_ff  <= rkey_in;
      rcon_ff  <= rcon_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = state_ff;

   a_round_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (round_ff >= 4'd1 && round_ff <= 4'd10)) else $error("round out of range");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("done without work");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("done while busy");

endmodule

// ===== tb/aes_cmac_engine_checker.sv =====
// Checker that predicts the CMAC and ECB results of the engine and compares the result words and their last flags.
`timescale 1ns / 1ps
module aes_cmac_engine_checker
   import acmac_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [63:0] req_data_word,
   input  logic [3:0]  req_valid_bytes,
   input  logic        req_message_end,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [63:0] rsp_tag_word,
   input  logic        rsp_tag_last,
   output int          mismatches,
   output int          outstanding
);

   typedef struct packed {
      logic [63:0] word;
      logic        last;
   } tag_half_type;

   logic [7:0]   sub_bytes_table [256];
   tag_half_type tags_due [$];
   logic [63:0]  key_hi;
   logic [63:0]  key_lo;
   logic         ecb_mode;
   logic [127:0] cbc_chain;
   logic [63:0]  first_half;
   logic         have_first_half;
   logic [127:0] subkey_k1;
   logic         subkey_ready;

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      logic [7:0] x;
      p = 8'h00;
      x = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p = p ^ x;
         x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
      end
      return p;
   endfunction

   function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
      return (x << n) | (x >> (8 - n));
   endfunction

   function automatic logic [7:0] mul2(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   initial begin
      logic [7:0] inv;
      for (int a = 0; a < 256; a++) begin
         inv = 8'h00;
         for (int b = 1; b < 256; b++) begin
            if (gf_mul(a[7:0], b[7:0]) == 8'h01) inv = b[7:0];
         end
         sub_bytes_table[a] = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3)
                              ^ rotl8(inv, 4) ^ 8'h63;
      end
   end

   function automatic logic [127:0] aes128_encrypt(input logic [127:0] key,
                                                   input logic [127:0] blk);
      logic [7:0] rk [176];
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] w [4];
      logic [7:0] tmp;
      logic [7:0] rc;
      logic [7:0] a0, a1, a2, a3, x;
      logic [127:0] res;
      rc = 8'h01;
      for (int i = 0; i < 16; i++) rk[i] = key[127 - 8 * i -: 8];
      for (int i = 16; i < 176; i += 4) begin
         for (int j = 0; j < 4; j++) w[j] = rk[i - 4 + j];
         if (i % 16 == 0) begin
            tmp = w[0];
            w[0] = sub_bytes_table[w[1]] ^ rc;
            w[1] = sub_bytes_table[w[2]];
            w[2] = sub_bytes_table[w[3]];
            w[3] = sub_bytes_table[tmp];
            rc = mul2(rc);
         end
         for (int j = 0; j < 4; j++) rk[i + j] = rk[i - 16 + j] ^ w[j];
      end
      for (int i = 0; i < 16; i++) s[i] = blk[127 - 8 * i -: 8] ^ rk[i];
      for (int r = 1; r <= 10; r++) begin
         for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) t[c * 4 + k] = sub_bytes_table[s[((c + k) % 4) * 4 + k]];
         end
         if (r < 10) begin
            for (int c = 0; c < 4; c++) begin
               a0 = t[c * 4];
               a1 = t[c * 4 + 1];
               a2 = t[c * 4 + 2];
               a3 = t[c * 4 + 3];
               x = a0 ^ a1 ^ a2 ^ a3;
               t[c * 4]     = a0 ^ x ^ mul2(a0 ^ a1);
               t[c * 4 + 1] = a1 ^ x ^ mul2(a1 ^ a2);
               t[c * 4 + 2] = a2 ^ x ^ mul2(a2 ^ a3);
               t[c * 4 + 3] = a3 ^ x ^ mul2(a3 ^ a0);
            end
         end
         for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[16 * r + i];
      end
      for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = s[i];
      return res;
   endfunction

   function automatic logic [127:0] double_block(input logic [127:0] v);
      return {v[126:0], 1'b0} ^ (v[127] ? {120'd0, CMAC_RB} : 128'd0);
   endfunction

   function automatic logic [63:0] pad_tail(input logic [63:0] w, input int n);
      logic [63:0] keep;
      keep = (n == 0) ? 64'd0 : ~64'd0 << (64 - 8 * n);
      return (w & keep) | ({56'd0, CMAC_PAD} << (56 - 8 * n));
   endfunction

   task automatic push_block_result(input logic [127:0] res);
      tags_due.push_back('{word: res[127:64], last: 1'b0});
      tags_due.push_back('{word: res[63:0], last: 1'b1});
   endtask

   task automatic predict_word(input logic [63:0] word, input logic [3:0] count,
                               input logic is_end);
      int n;
      logic [127:0] blk;
      logic [127:0] sub;
      logic complete;
      n = (count > 8) ? 8 : count;
      complete = 1'b0;
      if (ecb_mode) begin
         if (!have_first_half && !is_end) begin
            first_half = word;
            have_first_half = 1'b1;
         end else begin
            blk = have_first_half ? {first_half, word} : {word, 64'd0};
            have_first_half = 1'b0;
            push_block_result(aes128_encrypt({key_hi, key_lo}, blk));
         end
      end else if (!is_end) begin
         if (!have_first_half) begin
            first_half = word;
            have_first_half = 1'b1;
         end else begin
            cbc_chain = aes128_encrypt({key_hi, key_lo}, cbc_chain ^ {first_half, word});
            have_first_half = 1'b0;
         end
      end else begin
         if (have_first_half) begin
            if (n == 8) begin
               blk = {first_half, word};
               complete = 1'b1;
            end else begin
               blk = {first_half, pad_tail(word, n)};
            end
         end else if (n == 8) begin
            blk = {word, CMAC_PAD, 56'd0};
         end else begin
            blk = {pad_tail(word, n), 64'd0};
         end
         if (!subkey_ready) begin
            subkey_k1 = double_block(aes128_encrypt({key_hi, key_lo}, 128'd0));
            subkey_ready = 1'b1;
         end
         sub = complete ? subkey_k1 : double_block(subkey_k1);
         push_block_result(aes128_encrypt({key_hi, key_lo}, cbc_chain ^ blk ^ sub));
         cbc_chain = 128'd0;
         have_first_half = 1'b0;
      end
   endtask

   task automatic note_failure(input string what);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $realtime, what);
   endtask

   initial mismatches = 0;

   always @(posedge clock) begin
      tag_half_type due;
      if (reset) begin
         key_hi = 64'd0;
         key_lo = 64'd0;
         ecb_mode = 1'b0;
         cbc_chain = 128'd0;
         have_first_half = 1'b0;
         subkey_ready = 1'b0;
         tags_due.delete();
      end else begin
         if (csr_write && csr_index inside {CSR_KEY_HIGH, CSR_KEY_LOW, CSR_ENGINE_MODE}) begin
            case (csr_index)
               CSR_KEY_HIGH: begin
                  key_hi = csr_data;
                  subkey_ready = 1'b0;
               end
               CSR_KEY_LOW: begin
                  key_lo = csr_data;
                  subkey_ready = 1'b0;
               end
               CSR_ENGINE_MODE: begin
                  ecb_mode = csr_data[0];
               end
               default: begin
               end
            endcase
            cbc_chain = 128'd0;
            have_first_half = 1'b0;
         end
         if (rsp_valid && !rsp_stall) begin
            if (tags_due.size() == 0) begin
               note_failure($sformatf("unexpected result word %h last %b",
                                      rsp_tag_word, rsp_tag_last));
            end else begin
               due = tags_due.pop_front();
               if (rsp_tag_word !== due.word || rsp_tag_last !== due.last) begin
                  note_failure($sformatf("result word %h last %b, expected %h last %b",
                                         rsp_tag_word, rsp_tag_last, due.word, due.last));
               end
            end
         end
         if (req_valid && !req_stall) predict_word(req_data_word, req_valid_bytes,
                                                   req_message_end);
      end
      outstanding = tags_due.size();
   end

endmodule

// ===== tb/aes_cmac_engine_top_tb.sv =====
// Testbench top that drives the CMAC engine with directed and random messages and gives the verdict.
`timescale 1ns / 1ps
module aes_cmac_engine_top_tb;
   import acmac_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE_CYCLES = 40;

   logic        clock;
   logic        reset;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic [63:0] csr_data;
   logic        req_valid;
   logic        req_stall;
   logic [63:0] req_data_word;
   logic [3:0]  req_valid_bytes;
   logic        req_message_end;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_tag_word;
   logic        rsp_tag_last;
   int          mismatches;
   int          outstanding;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          hold_left;
   int          words_sent;
   int          cycle_count;

   aes_cmac_engine_top dut (.*);

   aes_cmac_engine_checker checker_inst (.*);

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("aes_cmac_engine_top_tb: done, errors");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic send_word(input logic [63:0] word, input logic [3:0] count,
                            input logic is_end);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data_word <= word;
      req_valid_bytes <= count;
      req_message_end <= is_end;
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [63:0] data);
      settle();
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   function automatic logic [63:0] pick_data();
      case ($urandom_range(9))
         0: return 64'd0;
         1: return ~64'd0;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [63:0] pick_key();
      case ($urandom_range(7))
         0: return 64'd0;
         1: return ~64'd0;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic send_message(input int words);
      logic [3:0] count;
      for (int i = 0; i < words; i++) begin
         if (i == words - 1) begin
            count = ($urandom_range(4) == 0) ? 4'($urandom_range(9, 15)) :
                    4'($urandom_range(0, 8));
         end else begin
            count = ($urandom_range(3) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
         end
         send_word(pick_data(), count, i == words - 1);
      end
   endtask

   task automatic reconfigure();
      case ($urandom_range(3))
         0: write_csr(CSR_KEY_HIGH, pick_key());
         1: write_csr(CSR_KEY_LOW, pick_key());
         default: write_csr(CSR_ENGINE_MODE, {$urandom, $urandom});
      endcase
   endtask

   initial begin
      cycle_count = 0;
      hold_left = 0;
      words_sent = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = 2'd0;
      csr_data = 64'd0;
      req_valid = 1'b0;
      req_data_word = 64'd0;
      req_valid_bytes = 4'd0;
      req_message_end = 1'b0;
      rsp_stall = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Zero key at reset: the empty message, then a complete block.
      send_word(64'd0, 4'd0, 1'b1);
      send_word(~64'd0, 4'd8, 1'b0);
      send_word(~64'd0, 4'd8, 1'b1);
      write_csr(CSR_KEY_HIGH, 64'h2b7e_1516_28ae_d2a6);
      write_csr(CSR_KEY_LOW, 64'habf7_1588_09cf_4f3c);
      send_word(64'h6bc1_bee2_2e40_9f96, 4'd8, 1'b0);
      send_word(64'he93d_7e11_7393_172a, 4'd8, 1'b1);
      send_word(64'h6bc1_bee2_2e40_9f96, 4'd8, 1'b1);
      send_word(64'h0123_4567_89ab_cdef, 4'd3, 1'b0);
      send_word(64'hfedc_ba98_7654_3210, 4'd15, 1'b1);
      for (int n = 0; n < 8; n++) send_word(64'h8899_aabb_ccdd_eeff, n[3:0], 1'b1);
      send_word(64'h1111_2222_3333_4444, 4'd8, 1'b0);
      write_csr(CSR_ENGINE_MODE, 64'd1);
      send_word(64'h0011_2233_4455_6677, 4'd5, 1'b0);
      send_word(64'h8899_aabb_ccdd_eeff, 4'd0, 1'b0);
      send_word(64'hdead_beef_cafe_f00d, 4'd2, 1'b1);
      write_csr(CSR_ENGINE_MODE, 64'd0);
      write_csr(CSR_KEY_HIGH, ~64'd0);
      write_csr(CSR_KEY_LOW, ~64'd0);
      send_word(64'h5555_aaaa_5555_aaaa, 4'd8, 1'b0);
      send_word(64'haaaa_5555_aaaa_5555, 4'd7, 1'b1);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 77 : 0;
         recv_idle_pct = (phase == 0) ? 77 : (phase == 1) ? 31 : 0;
         write_csr(CSR_KEY_HIGH, pick_key());
         write_csr(CSR_KEY_LOW, pick_key());
         write_csr(CSR_ENGINE_MODE, 64'(phase % 2));
         if (phase == 2) begin
            @(negedge clock);
            hold_left = 400;
            for (int m = 0; m < 12; m++) send_message(6);
         end
         while (words_sent < 25 + 333 * (phase + 1)) begin
            if ($urandom_range(7) == 0) reconfigure();
            send_message($urandom_range(1, 6));
         end
      end

      settle();
      if (mismatches == 0) begin
         $display("aes_cmac_engine_top_tb: done, clean");
      end else begin
         $display("aes_cmac_engine_top_tb: done, errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/acmac_pkg.sv
sv/acmac_aes_core.sv
sv/aes_cmac_engine_top.sv
tb/aes_cmac_engine_checker.sv
tb/aes_cmac_engine_top_tb.sv
